@@ design/mtf_pkg.sv @@
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared types and constants for the move-to-front coder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtf_pkg;

   localparam int DATA_W = 8;

   localparam logic MODE_ENCODE = 1'b0;
   localparam logic MODE_DECODE = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic start;     // Input transfer: latch the request.
      logic fetch;     // Read the list entry at the decode position.
      logic key_load;  // Take the fetched entry as the symbol to move.
      logic walk;      // Walk the list, shifting entries up by one.
      logic load_out;  // Move the result into the output register.
   } mtf_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic req_mode;  // Mode of the request at the input port.
      logic req_oor;   // Request byte lies outside the alphabet.
      logic match;     // Walk reached the symbol being moved.
      logic out_free;  // Output register can take a result this cycle.
   } mtf_sts_type;

endpackage

@@ design/mtf_ctrl.sv @@
// ----------------------------------------------------------------------------
// mtf_ctrl
// Sequencer for the move-to-front coder: accepts a request, steps the
// datapath through the list walk and hands the result to the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtf_ctrl
   import mtf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  mtf_sts_type sts,
   output mtf_cmd_type cmd
);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FETCH = 5'b00010,
      ST_KEY   = 5'b00100,
      ST_WALK  = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               if (sts.req_mode == MODE_DECODE) begin
                  state_in = ST_FETCH;
               end else if (sts.req_oor) begin
                  // Symbol not in the list: nothing moves, result is zero.
                  state_in = ST_DONE;
               end else begin
                  state_in = ST_WALK;
               end
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_KEY;
         end
         ST_KEY: begin
            cmd.key_load = 1'b1;
            state_in     = ST_WALK;
         end
         ST_WALK: begin
            cmd.walk = 1'b1;
            if (sts.match) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (sts.out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ design/mtf_datapath.sv @@
// ----------------------------------------------------------------------------
// mtf_datapath
// Symbol list memory with per-entry valid bits, the walk that shifts the
// list, and the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtf_datapath
   import mtf_pkg::*;
#(
   parameter int ALPHABET_SIZE = 256
)
(
   input  logic              clock,
   input  logic              reset,
   input  mtf_cmd_type       cmd,
   output mtf_sts_type       sts,
   input  logic              req_mode,
   input  logic              req_block_start,
   input  logic [DATA_W-1:0] req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_result_byte
);

   localparam int IDX_W = (ALPHABET_SIZE > 2) ? $clog2(ALPHABET_SIZE) : 1;
   localparam logic [DATA_W:0] LAST = (DATA_W + 1)'(ALPHABET_SIZE - 1);

   logic [DATA_W-1:0] mem [ALPHABET_SIZE];
   logic [ALPHABET_SIZE-1:0] valid_ff;

   logic              mode_ff;
   logic              oor_ff;
   logic [DATA_W-1:0] key_ff;
   logic [IDX_W-1:0]  pos_ff;
   logic [IDX_W-1:0]  rd_k_ff;
   logic              pend_ff;
   logic [DATA_W-1:0] prev_ff;
   logic [IDX_W-1:0]  rd_addr_ff;
   logic              rd_valid_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic [IDX_W-1:0]  hit_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic              rsp_valid_ff;

   logic              req_oor;
   logic [IDX_W-1:0]  rd_addr;
   logic [DATA_W-1:0] value;
   logic              wr_en;
   logic              match;
   logic [DATA_W-1:0] result;

   assign req_oor = {1'b0, req_data_byte} > LAST;
   assign rd_addr = cmd.fetch ? pos_ff : rd_k_ff;

   // An entry not written since the last block start holds its own index.
   assign value = rd_valid_ff ? rd_data_ff : DATA_W'(rd_addr_ff);

   assign wr_en = cmd.walk && pend_ff;
   assign match = wr_en && (value == key_ff);

   assign result = (mode_ff == MODE_DECODE) ? key_ff :
                   (oor_ff ? '0 : DATA_W'(hit_ff));

   assign sts.req_mode = req_mode;
   assign sts.req_oor  = req_oor;
   assign sts.match    = match;
   assign sts.out_free = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_byte = rsp_data_ff;

   // Symbol list storage: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[rd_addr_ff] <= prev_ff;
      end
      rd_data_ff  <= mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
      rd_addr_ff  <= rd_addr;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.start && req_block_start) begin
         valid_ff <= '0;
      end else if (wr_en) begin
         valid_ff[rd_addr_ff] <= 1'b1;
      end
   end

   // The walk reads entry k while the entry read the cycle before is
   // replaced by its predecessor; it stops where the moved symbol sat.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mode_ff <= req_mode;
         oor_ff  <= req_oor;
         key_ff  <= req_data_byte;
         prev_ff <= req_data_byte;
         pos_ff  <= req_oor ? LAST[IDX_W-1:0] : req_data_byte[IDX_W-1:0];
         rd_k_ff <= '0;
      end else if (cmd.key_load) begin
         key_ff  <= value;
         prev_ff <= value;
         rd_k_ff <= '0;
      end else if (cmd.walk) begin
         rd_k_ff <= rd_k_ff + IDX_W'(1);
         if (pend_ff) begin
            prev_ff <= value;
         end
      end
      if (match) begin
         hit_ff <= rd_addr_ff;
      end
      if (cmd.load_out) begin
         rsp_data_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pend_ff <= cmd.walk && !match;
         if (cmd.load_out) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

@@ design/move_to_front_codec_core.sv @@
// ----------------------------------------------------------------------------
// move_to_front_codec_core
// Byte-wide move-to-front encoder and decoder over a list of ALPHABET_SIZE
// symbols, with a block-start flag that restores identity order.
//
//   Channel   Ports                                      Direction
//   request   req_valid/ready, mode, block_start, data   in
//   response  rsp_valid/ready, result_byte               out
//
// Each request ends with its result entering the output register. An encode
// walks the list until it finds the symbol; a decode first fetches the entry
// at position p and takes it as the symbol to move. The walk goes through the
// list memory one entry per cycle. An encode of a symbol outside the alphabet
// skips the walk. Reset and block start clear the per-entry valid bits.
// A new request is taken while the previous result waits in the output
// register; a stalled output holds the walk's result until the slot frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module move_to_front_codec_core
   import mtf_pkg::*;
#(
   parameter int ALPHABET_SIZE = 256
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_mode,
   input  logic              req_block_start,
   input  logic [DATA_W-1:0] req_data_byte,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [DATA_W-1:0] rsp_result_byte
);

   mtf_cmd_type cmd;
   mtf_sts_type sts;

   mtf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mtf_datapath #(
      .ALPHABET_SIZE (ALPHABET_SIZE)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_mode        (req_mode),
      .req_block_start (req_block_start),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_result_byte (rsp_result_byte)
   );

endmodule
